>>> rtl/lzwd_pkg.sv
// Shared types and constants of the LZ window decompressor.
// Used by lzwd_fifo, lzwd_ctrl and the top level; depends on nothing.
`default_nettype none

package lzwd_pkg;

  // One compressed input item
  typedef struct packed {
    logic [7:0] in_byte;
  } in_item_t;

  // One decompressed result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_stream;
  } out_item_t;

  // Parser / copy sequencer states
  typedef enum logic [2:0] {
    ST_HDR_HI,
    ST_HDR_LO,
    ST_TOKEN,
    ST_PAIR_LO,
    ST_COPY
  } state_e;

  // Occupancy of the output queue as seen by the sequencer
  typedef struct packed {
    logic [1:0] count;
    logic       pop;
  } fifo_stat_t;

  localparam int unsigned FIFO_DEPTH    = 2;
  localparam logic [3:0]  FLAGS_PER_GRP = 4'd8;
  localparam logic [4:0]  MIN_MATCH     = 5'd3;
  localparam logic [12:0] MIN_BACK      = 13'd3;

endpackage

`default_nettype wire

>>> rtl/lzwd_stream_if.sv
// Valid/ready stream channel carrying one payload item per handshake.
// Payload type is a parameter; used with the item types of lzwd_pkg.
`default_nettype none

interface lzwd_stream_if #(
  parameter type T = logic [7:0]
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/lzwd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module lzwd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/lzwd_fifo.sv
// Two-entry output queue that decouples result delivery from the sequencer.
// Depends on lzwd_pkg and lzwd_stream_if.
`default_nettype none

module lzwd_fifo (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire lzwd_pkg::out_item_t   push_item_i,
  output lzwd_pkg::fifo_stat_t       stat_o,
  lzwd_stream_if.source              out_o
);

  lzwd_pkg::out_item_t slot_q [lzwd_pkg::FIFO_DEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign pop         = out_o.valid & out_o.ready;
  assign out_o.valid = (count_q != 2'd0);
  assign out_o.data  = slot_q[rd_ptr_q];
  assign stat_o      = '{count: count_q, pop: pop};

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed item
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/lzwd_ctrl.sv
// Stream parser and match copy sequencer; drives the history window memory
// and the output queue. Depends on lzwd_pkg and lzwd_stream_if.
`default_nettype none

module lzwd_ctrl #(
  parameter int unsigned DEPTH = 8192,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  lzwd_stream_if.sink                in_i,
  // history window memory
  output logic                       mem_we_o,
  output logic [AW-1:0]              mem_waddr_o,
  output logic [7:0]                 mem_wdata_o,
  output logic                       mem_re_o,
  output logic [AW-1:0]              mem_raddr_o,
  input  wire logic [7:0]            mem_rdata_i,
  // output queue
  output logic                       push_o,
  output lzwd_pkg::out_item_t        push_item_o,
  input  wire lzwd_pkg::fifo_stat_t  stat_i
);

  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(DEPTH);

  lzwd_pkg::state_e state_q, state_d;
  logic [15:0]   rem_q, rem_d;
  logic [7:0]    flag_bits_q, flag_bits_d;
  logic [3:0]    flags_left_q, flags_left_d;
  logic [7:0]    pair_hi_q, pair_hi_d;
  logic [AW-1:0] wp_q, wp_d;
  logic          wrapped_q, wrapped_d;
  logic [AW-1:0] src_q, src_d;
  logic [4:0]    cnt_q, cnt_d;
  logic          pend_q, pend_d;
  logic          pend_last_q, pend_last_d;
  logic          pend_end_q, pend_end_d;
  logic          pend_ok_q, pend_ok_d;

  logic          in_fire;
  logic          issue;
  logic [2:0]    occupancy;
  logic [7:0]    b;
  logic [12:0]   back;
  logic [AW:0]   back_ext;
  logic [AW:0]   wp_ext;
  logic [AW:0]   src_ext;
  logic [4:0]    len_raw;
  logic [4:0]    len;
  logic [15:0]   hdr_size;

  assign b         = in_i.data.in_byte;
  assign in_i.ready = (state_q != lzwd_pkg::ST_COPY) && !pend_q && (stat_i.count != 2'd2);
  assign in_fire   = in_i.valid & in_i.ready;

  // Queue slots taken or promised after this cycle's pop
  assign occupancy = {1'b0, stat_i.count} + {2'b00, pend_q} - {2'b00, stat_i.pop};
  assign issue     = (state_q == lzwd_pkg::ST_COPY) && (occupancy < 3'd2);

  // Decode the pair: source address and clipped length
  assign back     = {pair_hi_q, b[7:4]} + lzwd_pkg::MIN_BACK;
  assign back_ext = (AW + 1)'(back);
  assign wp_ext   = {1'b0, wp_q};
  assign src_ext  = (wp_ext >= back_ext) ? (wp_ext - back_ext)
                                         : (wp_ext + DEPTH_EXT - back_ext);
  assign len_raw  = {1'b0, b[3:0]} + lzwd_pkg::MIN_MATCH;
  assign len      = ({11'd0, len_raw} > rem_q) ? rem_q[4:0] : len_raw;
  assign hdr_size = {rem_q[15:8], b};

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lzwd_pkg::ST_HDR_HI: begin
        if (in_fire) state_d = lzwd_pkg::ST_HDR_LO;
      end
      lzwd_pkg::ST_HDR_LO: begin
        if (in_fire) begin
          state_d = (hdr_size == 16'd0) ? lzwd_pkg::ST_HDR_HI : lzwd_pkg::ST_TOKEN;
        end
      end
      lzwd_pkg::ST_TOKEN: begin
        if (in_fire && (flags_left_q != 4'd0)) begin
          if (flag_bits_q[7]) begin
            state_d = lzwd_pkg::ST_PAIR_LO;
          end else if (rem_q == 16'd1) begin
            state_d = lzwd_pkg::ST_HDR_HI;
          end
        end
      end
      lzwd_pkg::ST_PAIR_LO: begin
        if (in_fire) state_d = lzwd_pkg::ST_COPY;
      end
      lzwd_pkg::ST_COPY: begin
        if (issue && (cnt_q == 5'd1)) begin
          state_d = (rem_q == 16'd1) ? lzwd_pkg::ST_HDR_HI : lzwd_pkg::ST_TOKEN;
        end
      end
      default: state_d = lzwd_pkg::ST_HDR_HI;
    endcase
  end

  // Datapath, memory and queue control
  always_comb begin
    rem_d        = rem_q;
    flag_bits_d  = flag_bits_q;
    flags_left_d = flags_left_q;
    pair_hi_d    = pair_hi_q;
    wp_d         = wp_q;
    wrapped_d    = wrapped_q;
    src_d        = src_q;
    cnt_d        = cnt_q;
    pend_d       = issue;
    pend_last_d  = pend_last_q;
    pend_end_d   = pend_end_q;
    pend_ok_d    = pend_ok_q;
    mem_we_o     = 1'b0;
    mem_wdata_o  = b;
    mem_re_o     = 1'b0;
    mem_raddr_o  = src_q;
    push_o       = 1'b0;
    push_item_o  = '{out_byte: b, last_of_run: 1'b1, end_of_stream: (rem_q == 16'd1)};

    unique case (state_q)
      lzwd_pkg::ST_HDR_HI: begin
        if (in_fire) rem_d = {b, 8'h00};
      end
      lzwd_pkg::ST_HDR_LO: begin
        if (in_fire) begin
          rem_d        = hdr_size;
          flags_left_d = 4'd0;
          flag_bits_d  = 8'h00;
        end
      end
      lzwd_pkg::ST_TOKEN: begin
        if (in_fire) begin
          if (flags_left_q == 4'd0) begin
            // fetch a new flag group
            flag_bits_d  = b;
            flags_left_d = lzwd_pkg::FLAGS_PER_GRP;
          end else begin
            flag_bits_d  = {flag_bits_q[6:0], 1'b0};
            flags_left_d = flags_left_q - 4'd1;
            if (flag_bits_q[7]) begin
              pair_hi_d = b;
            end else begin
              // literal: emit and record in the window
              mem_we_o = 1'b1;
              push_o   = 1'b1;
              rem_d    = rem_q - 16'd1;
            end
          end
        end
      end
      lzwd_pkg::ST_PAIR_LO: begin
        if (in_fire) begin
          src_d = src_ext[AW-1:0];
          cnt_d = len;
        end
      end
      lzwd_pkg::ST_COPY: begin
        if (issue) begin
          // read one match byte; never-written entries read as zero
          mem_re_o    = 1'b1;
          src_d       = (src_q == LAST_ADDR) ? '0 : src_q + AW'(1);
          rem_d       = rem_q - 16'd1;
          cnt_d       = cnt_q - 5'd1;
          pend_last_d = (cnt_q == 5'd1);
          pend_end_d  = (rem_q == 16'd1);
          pend_ok_d   = wrapped_q || (src_q < wp_q);
        end
      end
      default: ;
    endcase

    // Match byte returns from memory: write back and emit
    if (pend_q) begin
      mem_we_o    = 1'b1;
      mem_wdata_o = pend_ok_q ? mem_rdata_i : 8'h00;
      push_o      = 1'b1;
      push_item_o = '{out_byte: mem_wdata_o, last_of_run: pend_last_q,
                      end_of_stream: pend_end_q};
    end

    // Advance the write position
    if (mem_we_o) begin
      wp_d = (wp_q == LAST_ADDR) ? '0 : wp_q + AW'(1);
      if (wp_q == LAST_ADDR) wrapped_d = 1'b1;
    end
  end

  assign mem_waddr_o = wp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lzwd_pkg::ST_HDR_HI;
      rem_q        <= 16'd0;
      flag_bits_q  <= 8'h00;
      flags_left_q <= 4'd0;
      pair_hi_q    <= 8'h00;
      wp_q         <= '0;
      wrapped_q    <= 1'b0;
      cnt_q        <= 5'd0;
      pend_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      rem_q        <= rem_d;
      flag_bits_q  <= flag_bits_d;
      flags_left_q <= flags_left_d;
      pair_hi_q    <= pair_hi_d;
      wp_q         <= wp_d;
      wrapped_q    <= wrapped_d;
      cnt_q        <= cnt_d;
      pend_q       <= pend_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    src_q       <= src_d;
    pend_last_q <= pend_last_d;
    pend_end_q  <= pend_end_d;
    pend_ok_q   <= pend_ok_d;
  end

endmodule

`default_nettype wire

>>> rtl/lz_window_decompressor.sv
// LZSS decompressor (12-bit distance, 4-bit length) over a byte stream, top level.
// Takes one compressed byte per item and returns one item per output byte. After a
// pair-low byte the copy reads the history window once per output byte through the
// single read port of the window memory, and the next byte is taken after the last
// copied byte has been written back. The window needs no clearing pass after reset:
// a write position and a wrap flag mark which entries hold data, and entries never
// written read as zero. A two-entry output queue lets the copy run at one byte per
// cycle while results are taken.
// Depends on lzwd_pkg, lzwd_stream_if, lzwd_ram, lzwd_fifo and lzwd_ctrl.
`default_nettype none

module lz_window_decompressor #(
  parameter int unsigned WINDOW_DEPTH = 8192
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  lzwd_stream_if.sink   in_i,
  lzwd_stream_if.source out_o
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [7:0]           mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [7:0]           mem_rdata;
  logic                 push;
  lzwd_pkg::out_item_t  push_item;
  lzwd_pkg::fifo_stat_t stat;

  // Parser and copy sequencer
  lzwd_ctrl #(
    .DEPTH (WINDOW_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .push_o      (push),
    .push_item_o (push_item),
    .stat_i      (stat)
  );

  // History window
  lzwd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output queue
  lzwd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .stat_o      (stat),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
